@@ rtl/crlp_pkg.sv @@
// ----------------------------------------------------------------------------
// crlp_pkg
// Shared types and constants for the CPU range list parser: character codes,
// status codes and the item and result records passed between stages.
// ----------------------------------------------------------------------------
package crlp_pkg;

  // Default largest CPU id accepted
  localparam int MaxCpuIdDef = 4095;

  // Range fields on the output are always this wide
  localparam int RangeW = 12;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;

  // Status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_MISSING   = 3'd1;
  localparam logic [2:0] ST_NONDIGIT  = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_REVERSED  = 3'd4;
  localparam logic [2:0] ST_ORDER     = 3'd5;

  // One text item as held in the input register
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } item_t;

  // One result transaction
  typedef struct packed {
    logic [RangeW-1:0] range_first;
    logic [RangeW-1:0] range_last;
    logic              has_range;
    logic [2:0]        status;
    logic              final_result;
  } result_t;

endpackage

@@ rtl/cpu_range_list_parser.sv @@
// ----------------------------------------------------------------------------
// cpu_range_list_parser
// Parses a CPU list such as "0-3,5,8-11", one character per transaction,
// and returns each completed element as a range.
//
// Input channel: in_valid_i/in_stall_o carry char_code_i, or end_of_text_i
// to close the list. Output channel: out_valid_o/out_stall_i carry one range
// per valid element ended by a comma, and one final transaction for the end
// item with the list status. When the final status is not ok, the ranges
// already sent for that list are to be discarded.
// An accepted character is loaded into the input register; the parse logic
// then works out its result, which is loaded into the result register and
// presented from there.
// The block takes one character per cycle while its input is not stalled,
// set by the parse stage that updates the list state.
// Reset clears the list state and empties both registers.
// While the receiver stalls, the result holds; the block keeps taking
// characters that produce no result, and stalls its input only when a
// further result is ready with the result register still full.
// ----------------------------------------------------------------------------
module cpu_range_list_parser #(
  parameter int MAX_CPU_ID = crlp_pkg::MaxCpuIdDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  char_code_i,
  input  logic                        end_of_text_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [crlp_pkg::RangeW-1:0] range_first_o,
  output logic [crlp_pkg::RangeW-1:0] range_last_o,
  output logic                        has_range_o,
  output logic [2:0]                  status_o,
  output logic                        final_result_o
);
  import crlp_pkg::*;

  item_t   item_in;
  item_t   item_q;
  logic    item_valid;
  logic    advance;
  logic    res_valid;
  logic    out_free;
  result_t res_d;
  result_t res_q;

  assign item_in.char_code   = char_code_i;
  assign item_in.end_of_text = end_of_text_i;

  // Input register
  crlp_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .item_i       (item_in),
    .item_valid_o (item_valid),
    .item_o       (item_q),
    .advance_i    (advance)
  );

  // Parse stage
  crlp_core #(
    .MAX_CPU_ID (MAX_CPU_ID)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item_q),
    .out_free_i   (out_free),
    .advance_o    (advance),
    .res_valid_o  (res_valid),
    .res_o        (res_d)
  );

  // Result register
  crlp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && res_valid),
    .res_i       (res_d),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res_q)
  );

  assign range_first_o  = res_q.range_first;
  assign range_last_o   = res_q.range_last;
  assign has_range_o    = res_q.has_range;
  assign status_o       = res_q.status;
  assign final_result_o = res_q.final_result;

`ifndef SYNTHESIS
  // A non-ok status only ever comes with the final transaction
  a_status_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> final_result_o)
    else $error("error status on a non-final result");

  // Intermediate results always carry a range
  a_mid_has_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !final_result_o) |-> has_range_o)
    else $error("intermediate result without a range");

  // Empty range fields read as zero
  a_no_range_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_range_o) |-> ((range_first_o == '0) && (range_last_o == '0)))
    else $error("range fields not cleared without a range");

  // A valid range is never reversed
  a_range_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && has_range_o && (MAX_CPU_ID < 4096)) |-> (range_first_o <= range_last_o))
    else $error("reversed range emitted");
`endif

endmodule

@@ rtl/crlp_in_reg.sv @@
// ----------------------------------------------------------------------------
// crlp_in_reg
// Input register of the parser. Takes one text item per cycle unless stalled
// and holds it until the parse stage consumes it.
// ----------------------------------------------------------------------------
module crlp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  crlp_pkg::item_t item_i,
  output logic           item_valid_o,
  output crlp_pkg::item_t item_o,
  input  logic           advance_i
);
  import crlp_pkg::*;

  logic  valid_q;
  logic  valid_d;
  logic  accept;
  item_t item_q;

  // Stall only while the held item cannot move on
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Load payload on every accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

@@ rtl/crlp_core.sv @@
// ----------------------------------------------------------------------------
// crlp_core
// Parse stage. Holds the list state and works out, in one pass, the state
// update and the optional result for the item in the input register.
// ----------------------------------------------------------------------------
module crlp_core #(
  parameter int MAX_CPU_ID = crlp_pkg::MaxCpuIdDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  crlp_pkg::item_t  item_i,
  input  logic             out_free_i,
  output logic             advance_o,
  output logic             res_valid_o,
  output crlp_pkg::result_t res_o
);
  import crlp_pkg::*;

  localparam int IdW   = $clog2(MAX_CPU_ID + 1);
  localparam int ProdW = IdW + 4;

  logic           in2_q, in2_d;
  logic           seen_q, seen_d;
  logic [IdW-1:0] acc_q, acc_d;
  logic [IdW-1:0] start_q, start_d;
  logic           have_q, have_d;
  logic [IdW-1:0] prev_q, prev_d;
  logic [2:0]     err_q, err_d;
  logic           any_q, any_d;

  logic             is_digit;
  logic [3:0]       digit;
  logic [ProdW-1:0] prod;
  logic [IdW-1:0]   fin_first;
  logic [2:0]       fin_st;
  logic [31:0]      first_ext;
  logic [31:0]      last_ext;
  logic             res_valid;

  // Next accumulator value: acc*10 + digit
  assign is_digit = (item_i.char_code >= CH_ZERO) && (item_i.char_code <= CH_NINE);
  assign digit    = 4'(item_i.char_code - CH_ZERO);
  assign prod     = (ProdW'(acc_q) << 3) + (ProdW'(acc_q) << 1) + ProdW'(digit);

  // Check the element that ends here
  assign fin_first = in2_q ? start_q : acc_q;
  always_comb begin
    if (!seen_q) begin
      fin_st = ST_MISSING;
    end else if (in2_q && (acc_q < start_q)) begin
      fin_st = ST_REVERSED;
    end else if (have_q && (fin_first <= prev_q)) begin
      fin_st = ST_ORDER;
    end else begin
      fin_st = ST_OK;
    end
  end

  assign first_ext = 32'(fin_first);
  assign last_ext  = 32'(acc_q);

  // State update and result
  always_comb begin
    in2_d     = in2_q;
    seen_d    = seen_q;
    acc_d     = acc_q;
    start_d   = start_q;
    have_d    = have_q;
    prev_d    = prev_q;
    err_d     = err_q;
    any_d     = any_q;
    res_valid = 1'b0;
    res_o     = '0;
    if (item_i.end_of_text) begin
      res_valid          = 1'b1;
      res_o.final_result = 1'b1;
      if (err_q != ST_OK) begin
        res_o.status = err_q;
      end else if (any_q) begin
        res_o.status = fin_st;
        if (fin_st == ST_OK) begin
          res_o.has_range   = 1'b1;
          res_o.range_first = first_ext[RangeW-1:0];
          res_o.range_last  = last_ext[RangeW-1:0];
        end
      end
      // Back to reset values for the next list
      in2_d   = 1'b0;
      seen_d  = 1'b0;
      acc_d   = '0;
      start_d = '0;
      have_d  = 1'b0;
      prev_d  = '0;
      err_d   = ST_OK;
      any_d   = 1'b0;
    end else begin
      any_d = 1'b1;
      if (err_q == ST_OK) begin
        if (is_digit) begin
          acc_d  = prod[IdW-1:0];
          seen_d = 1'b1;
          if (prod > ProdW'(MAX_CPU_ID)) begin
            err_d = ST_TOO_LARGE;
          end
        end else if (item_i.char_code == CH_DASH) begin
          if (in2_q) begin
            err_d = ST_NONDIGIT;
          end else if (!seen_q) begin
            err_d = ST_MISSING;
          end else begin
            start_d = acc_q;
            acc_d   = '0;
            seen_d  = 1'b0;
            in2_d   = 1'b1;
          end
        end else if (item_i.char_code == CH_COMMA) begin
          in2_d   = 1'b0;
          seen_d  = 1'b0;
          acc_d   = '0;
          start_d = '0;
          if (fin_st != ST_OK) begin
            err_d = fin_st;
          end else begin
            have_d            = 1'b1;
            prev_d            = acc_q;
            res_valid         = 1'b1;
            res_o.has_range   = 1'b1;
            res_o.range_first = first_ext[RangeW-1:0];
            res_o.range_last  = last_ext[RangeW-1:0];
          end
        end else begin
          err_d = ST_NONDIGIT;
        end
      end
    end
  end

  // Consume the item unless its result has nowhere to go
  assign advance_o   = item_valid_i && (!res_valid || out_free_i);
  assign res_valid_o = item_valid_i && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in2_q   <= 1'b0;
      seen_q  <= 1'b0;
      acc_q   <= '0;
      start_q <= '0;
      have_q  <= 1'b0;
      prev_q  <= '0;
      err_q   <= ST_OK;
      any_q   <= 1'b0;
    end else if (advance_o) begin
      in2_q   <= in2_d;
      seen_q  <= seen_d;
      acc_q   <= acc_d;
      start_q <= start_d;
      have_q  <= have_d;
      prev_q  <= prev_d;
      err_q   <= err_d;
      any_q   <= any_d;
    end
  end

endmodule

@@ rtl/crlp_out_reg.sv @@
// ----------------------------------------------------------------------------
// crlp_out_reg
// Result register. Holds one result transaction until the receiver takes it
// and reports whether a new result can be loaded this cycle.
// ----------------------------------------------------------------------------
module crlp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  crlp_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output crlp_pkg::result_t res_o
);
  import crlp_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  // Free when empty or being emptied this cycle
  assign free_o  = !valid_q || !out_stall_i;
  assign valid_d = load_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

@@ test/tb_cpu_range_list_parser.sv @@
// ----------------------------------------------------------------------------
// tb_cpu_range_list_parser
// Self-checking testbench for the CPU range list parser. Feeds CPU list text
// one character per transaction: a short directed set of lists covering the
// error kinds and the id limits, then random lists, mostly well formed with
// some corrupted. A scoreboard predicts the emitted ranges and the final
// status of every list and checks each result transaction field by field.
// The sender works in bursts with random gaps; the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------

// Predicts the parser's output and checks what comes back
class range_list_scoreboard;

  // Parser state
  bit              second_id;
  bit              have_digit;
  int unsigned     cur_value;
  int unsigned     first_id;
  bit              have_prev;
  int unsigned     prev_last;
  logic [2:0]      list_status;
  bit              text_started;

  crlp_pkg::result_t pending[$];
  int unsigned       n_mismatch;
  int unsigned       n_parsed;

  function void clear_element();
    second_id  = 1'b0;
    have_digit = 1'b0;
    cur_value  = 0;
    first_id   = 0;
  endfunction

  function void clear_list();
    clear_element();
    have_prev    = 1'b0;
    prev_last    = 0;
    list_status  = crlp_pkg::ST_OK;
    text_started = 1'b0;
  endfunction

  function new();
    clear_list();
    n_mismatch = 0;
    n_parsed   = 0;
  endfunction

  // Check the element just ended; on success record it as the previous one
  function void close_element(output logic [2:0] st, output int unsigned lo_id,
                              output int unsigned hi_id);
    lo_id = 0;
    hi_id = 0;
    st    = crlp_pkg::ST_OK;
    if (!have_digit) begin
      st = crlp_pkg::ST_MISSING;
    end else begin
      lo_id = second_id ? first_id : cur_value;
      hi_id = cur_value;
      if (second_id && hi_id < lo_id) begin
        st = crlp_pkg::ST_REVERSED;
      end else if (have_prev && lo_id <= prev_last) begin
        st = crlp_pkg::ST_ORDER;
      end else begin
        have_prev = 1'b1;
        prev_last = hi_id;
      end
    end
  endfunction

  // Advance the prediction by one accepted input transaction
  function void note_item(logic [7:0] ch, logic eot);
    logic [2:0]        st;
    int unsigned       lo_id;
    int unsigned       hi_id;
    crlp_pkg::result_t r;
    r = '0;
    if (eot) begin
      n_parsed++;
      r.final_result = 1'b1;
      if (list_status != crlp_pkg::ST_OK) begin
        r.status = list_status;
      end else if (text_started) begin
        close_element(st, lo_id, hi_id);
        r.status = st;
        if (st == crlp_pkg::ST_OK) begin
          r.has_range   = 1'b1;
          r.range_first = lo_id[11:0];
          r.range_last  = hi_id[11:0];
        end
      end
      pending.insert(pending.size(), r);
      clear_list();
      return;
    end
    text_started = 1'b1;
    // drop characters once the list has failed
    if (list_status != crlp_pkg::ST_OK) return;
    n_parsed++;
    if (ch >= crlp_pkg::CH_ZERO && ch <= crlp_pkg::CH_NINE) begin
      cur_value  = cur_value * 10 + (ch - crlp_pkg::CH_ZERO);
      have_digit = 1'b1;
      if (cur_value > crlp_pkg::MaxCpuIdDef) list_status = crlp_pkg::ST_TOO_LARGE;
    end else if (ch == crlp_pkg::CH_DASH) begin
      if (second_id) begin
        list_status = crlp_pkg::ST_NONDIGIT;
      end else if (!have_digit) begin
        list_status = crlp_pkg::ST_MISSING;
      end else begin
        first_id   = cur_value;
        cur_value  = 0;
        have_digit = 1'b0;
        second_id  = 1'b1;
      end
    end else if (ch == crlp_pkg::CH_COMMA) begin
      close_element(st, lo_id, hi_id);
      clear_element();
      if (st != crlp_pkg::ST_OK) begin
        list_status = st;
      end else begin
        r.has_range   = 1'b1;
        r.range_first = lo_id[11:0];
        r.range_last  = hi_id[11:0];
        pending.insert(pending.size(), r);
      end
    end else begin
      list_status = crlp_pkg::ST_NONDIGIT;
    end
  endfunction

  task report(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    n_mismatch++;
  endtask

  // Compare one accepted result with the oldest expectation
  task check_result(crlp_pkg::result_t got);
    crlp_pkg::result_t want;
    if (pending.size() == 0) begin
      report($sformatf("unexpected result first=%0d last=%0d has=%0b st=%0d fin=%0b",
                       got.range_first, got.range_last, got.has_range, got.status,
                       got.final_result));
      return;
    end
    want = pending.pop_front();
    if (got.range_first !== want.range_first)
      report($sformatf("range_first %0d, want %0d", got.range_first, want.range_first));
    if (got.range_last !== want.range_last)
      report($sformatf("range_last %0d, want %0d", got.range_last, want.range_last));
    if (got.has_range !== want.has_range)
      report($sformatf("has_range %0b, want %0b", got.has_range, want.has_range));
    if (got.status !== want.status)
      report($sformatf("status %0d, want %0d", got.status, want.status));
    if (got.final_result !== want.final_result)
      report($sformatf("final_result %0b, want %0b", got.final_result, want.final_result));
  endtask

endclass

module tb_cpu_range_list_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;
  localparam int RandomItems   = 1100;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_e;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [7:0]                  char_code_i;
  logic                        end_of_text_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [crlp_pkg::RangeW-1:0] range_first_o;
  logic [crlp_pkg::RangeW-1:0] range_last_o;
  logic                        has_range_o;
  logic [2:0]                  status_o;
  logic                        final_result_o;

  range_list_scoreboard sb = new();

  bit [7:0]    list_text[$];
  int          burst_left;
  int          idle_cycles;
  stall_mode_e stall_mode;
  int          mode_left;
  int          stall_left;

  cpu_range_list_parser DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .char_code_i    (char_code_i),
    .end_of_text_i  (end_of_text_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .range_first_o  (range_first_o),
    .range_last_o   (range_last_o),
    .has_range_o    (has_range_o),
    .status_o       (status_o),
    .final_result_o (final_result_o)
  );

  // 10 ns clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both channels; note inputs and check results
  always @(posedge clk_i) begin
    crlp_pkg::result_t got;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_item(char_code_i, end_of_text_i);
      if (out_valid_o && !out_stall_i) begin
        got.range_first  = range_first_o;
        got.range_last   = range_last_o;
        got.has_range    = has_range_o;
        got.status       = status_o;
        got.final_result = final_result_o;
        sb.check_result(got);
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAIL cpu_range_list_parser");
        $finish;
      end
    end
  end

  // Receiver stall, switching between calm, random and bursty stretches
  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left  = $urandom_range(20, 300);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall_i <= ($urandom_range(0, 99) < 35);
      end
      default: begin
        if (stall_left > 0) begin
          stall_left--;
          out_stall_i <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
          stall_left = $urandom_range(1, 11);
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    endcase
  end

  // Offer one transaction and hold it until taken; gaps fall between bursts
  task automatic send_item(logic [7:0] ch, logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 20);
    end
    in_valid_i    <= 1'b1;
    char_code_i   <= ch;
    end_of_text_i <= eot;
    do @(posedge clk_i); while (in_stall_o);
    burst_left--;
  endtask

  // Send the buffered list text, then the end item with a junk character
  task automatic send_list();
    foreach (list_text[i]) send_item(list_text[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    list_text.delete();
  endtask

  // Append one byte to the list text
  function automatic void put_byte(bit [7:0] b);
    list_text.insert(list_text.size(), b);
  endfunction

  function automatic void put_str(string s);
    foreach (s[i]) put_byte(s[i]);
  endfunction

  function automatic void put_num(int value, int zeros);
    repeat (zeros) put_byte(crlp_pkg::CH_ZERO);
    put_str($sformatf("%0d", value));
  endfunction

  // Next id at or above base, now and then anywhere or near the top limit
  function automatic int pick_id(int base);
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return base + $urandom_range(0, 5);
    if (r < 17) return base + $urandom_range(0, 300);
    if (r < 19) return $urandom_range(0, crlp_pkg::MaxCpuIdDef);
    return $urandom_range(4088, 4110);
  endfunction

  function automatic bit [7:0] noise_byte();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return crlp_pkg::CH_COMMA;
      2:       return crlp_pkg::CH_DASH;
      default: return crlp_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  // Build one random list, mostly well formed, sometimes damaged
  function automatic void build_random_list();
    int n_elem;
    int prev;
    int lo_id;
    int hi_id;
    int pos;
    n_elem = $urandom_range(0, 6);
    prev   = -1;
    for (int e = 0; e < n_elem; e++) begin
      if (e > 0) put_byte(crlp_pkg::CH_COMMA);
      lo_id = pick_id(prev + 1);
      put_num(lo_id, ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : 0);
      prev = lo_id;
      if ($urandom_range(0, 9) < 4) begin
        put_byte(crlp_pkg::CH_DASH);
        hi_id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, lo_id) : pick_id(lo_id);
        put_num(hi_id, ($urandom_range(0, 15) == 0) ? 1 : 0);
        prev = hi_id;
      end
    end
    if ($urandom_range(0, 19) == 0) put_byte(crlp_pkg::CH_COMMA);
    // damage a fifth of the lists
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 2)) begin
        pos = $urandom_range(0, list_text.size());
        case ($urandom_range(0, 2))
          0: list_text.insert(pos, noise_byte());
          1: if (pos < list_text.size()) list_text[pos] = noise_byte();
          default: if (pos < list_text.size()) list_text.delete(pos);
        endcase
      end
    end
  endfunction

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    char_code_i   = '0;
    end_of_text_i = 1'b0;
    out_stall_i   = 1'b0;
    burst_left    = 0;
    idle_cycles   = 0;
    mode_left     = 0;
    stall_left    = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lists: empty text, limits, each error kind
    send_list();
    put_str("0-3,5,8-11");  send_list();
    put_str("4095");        send_list();
    put_str("4096");        send_list();
    put_str("0004095");     send_list();
    put_str("7-7,9");       send_list();
    put_str("5-3");         send_list();
    put_str("3,3");         send_list();
    put_str("1--2");        send_list();
    put_str(",1");          send_list();
    put_str("1,");          send_list();
    put_str("2-");          send_list();
    put_str("1 2");         send_list();
    put_byte(8'h00);
    send_list();
    put_str("1,");
    put_byte(8'hFF);
    put_str(",5");
    send_list();

    // Random lists
    while (sb.n_parsed < RandomItems) begin
      build_random_list();
      send_list();
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for anything stray
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.pending.size()));
    if (sb.n_mismatch == 0) begin
      $display("PASS cpu_range_list_parser");
    end else begin
      $display("FAIL cpu_range_list_parser");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/crlp_pkg.sv
rtl/crlp_in_reg.sv
rtl/crlp_core.sv
rtl/crlp_out_reg.sv
rtl/cpu_range_list_parser.sv
test/tb_cpu_range_list_parser.sv
